[rtl/dbbt_pkg.sv]
// Shared types and constants for the DMA bandwidth budget throttle.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package dbbt_pkg;

    // Number of tracked DMA devices and the number of class registers.
    localparam int NUM_DEVICES = 4;
    localparam int CLASS_REGS  = 4;

    // Field and counter widths.
    localparam int OP_W     = 2;
    localparam int DEV_W    = 2;
    localparam int BYTES_W  = 32;
    localparam int LIFE_W   = 48;
    localparam int TICK_W   = 40;
    localparam int STALL_W  = 32;
    localparam int BUDGET_W = 32;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths; the data widths are padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_REPORT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_TICK   = 2'd2,
        OP_STATS  = 2'd3
    } op_t;

    // Priority classes of a device.
    typedef enum logic [1:0] {
        CLASS_RT     = 2'd0,
        CLASS_HIGH   = 2'd1,
        CLASS_NORMAL = 2'd2,
        CLASS_LOW    = 2'd3
    } class_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_DEV0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_DEV3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET_NORM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET_LOW   = 3'd6;

    // Reset values of the configuration registers.
    localparam class_t CLASS_RESET [CLASS_REGS] =
        '{CLASS_HIGH, CLASS_RT, CLASS_NORMAL, CLASS_LOW};
    localparam logic [BUDGET_W-1:0] BUDGET_HIGH_RESET = 32'd24536678;
    localparam logic [BUDGET_W-1:0] BUDGET_NORM_RESET = 32'd8178892;
    localparam logic [BUDGET_W-1:0] BUDGET_LOW_RESET  = 32'd4089446;

    // Current configuration as seen by the counter bank.
    typedef struct packed {
        class_t [CLASS_REGS-1:0] dev_class;
        logic [BUDGET_W-1:0]     budget_high;
        logic [BUDGET_W-1:0]     budget_normal;
        logic [BUDGET_W-1:0]     budget_low;
    } cfg_t;

    // One input item.
    typedef struct packed {
        op_t                 op;
        logic [DEV_W-1:0]    device;
        logic [BYTES_W-1:0]  byte_count;
    } item_t;

    // One result item.
    typedef struct packed {
        logic                defer;
        logic [LIFE_W-1:0]   total_bytes;
        logic [STALL_W-1:0]  stall_count;
    } result_t;

endpackage

`default_nettype wire

[rtl/dbbt_cfg_regs.sv]
// Configuration registers of the DMA bandwidth budget throttle.
// Depends on dbbt_pkg for the register indexes and reset values.
`default_nettype none

module dbbt_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [dbbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dbbt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output dbbt_pkg::cfg_t                        cfg
);

    dbbt_pkg::class_t              class_reg [dbbt_pkg::CLASS_REGS];
    logic [dbbt_pkg::BUDGET_W-1:0] budget_high_reg;
    logic [dbbt_pkg::BUDGET_W-1:0] budget_normal_reg;
    logic [dbbt_pkg::BUDGET_W-1:0] budget_low_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_reg         <= dbbt_pkg::CLASS_RESET;
            budget_high_reg   <= dbbt_pkg::BUDGET_HIGH_RESET;
            budget_normal_reg <= dbbt_pkg::BUDGET_NORM_RESET;
            budget_low_reg    <= dbbt_pkg::BUDGET_LOW_RESET;
        end else if (cfg_we) begin
            priority if (cfg_index <= dbbt_pkg::REG_CLASS_DEV3) begin
                class_reg[cfg_index[1:0]] <= dbbt_pkg::class_t'(cfg_wdata[1:0]);
            end else if (cfg_index == dbbt_pkg::REG_BUDGET_HIGH) begin
                budget_high_reg <= cfg_wdata;
            end else if (cfg_index == dbbt_pkg::REG_BUDGET_NORM) begin
                budget_normal_reg <= cfg_wdata;
            end else if (cfg_index == dbbt_pkg::REG_BUDGET_LOW) begin
                budget_low_reg <= cfg_wdata;
            end
        end
    end

    // Pack the configuration for the counter bank.
    always_comb begin
        for (int i = 0; i < dbbt_pkg::CLASS_REGS; i++) begin
            cfg.dev_class[i] = class_reg[i];
        end
        cfg.budget_high   = budget_high_reg;
        cfg.budget_normal = budget_normal_reg;
        cfg.budget_low    = budget_low_reg;
    end

endmodule

`default_nettype wire

[rtl/dbbt_counter_bank.sv]
// Per-device byte, per-tick and stall counters with their update logic.
// Depends on dbbt_pkg for the item, result and configuration types.
`default_nettype none

module dbbt_counter_bank (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dbbt_pkg::cfg_t cfg,
    input  wire logic      item_valid,
    input  wire dbbt_pkg::item_t item,
    output dbbt_pkg::result_t res
);

    logic [dbbt_pkg::LIFE_W-1:0]  life_reg   [dbbt_pkg::NUM_DEVICES];
    logic [dbbt_pkg::LIFE_W-1:0]  life_next  [dbbt_pkg::NUM_DEVICES];
    logic [dbbt_pkg::TICK_W-1:0]  tick_reg   [dbbt_pkg::NUM_DEVICES];
    logic [dbbt_pkg::TICK_W-1:0]  tick_next  [dbbt_pkg::NUM_DEVICES];
    logic [dbbt_pkg::STALL_W-1:0] stall_reg  [dbbt_pkg::NUM_DEVICES];
    logic [dbbt_pkg::STALL_W-1:0] stall_next [dbbt_pkg::NUM_DEVICES];

    logic                          dev_ok;
    logic [dbbt_pkg::LIFE_W-1:0]   life_cur;
    logic [dbbt_pkg::LIFE_W-1:0]   life_sum;
    logic [dbbt_pkg::TICK_W-1:0]   tick_cur;
    logic [dbbt_pkg::TICK_W:0]     tick_sum;
    logic [dbbt_pkg::TICK_W-1:0]   tick_sat;
    logic [dbbt_pkg::STALL_W-1:0]  stall_cur;
    logic [dbbt_pkg::STALL_W-1:0]  stall_inc;
    dbbt_pkg::class_t              cls;
    logic [dbbt_pkg::BUDGET_W-1:0] budget;
    logic                          defer_hit;

    // Read the addressed device and form the candidate updates.
    always_comb begin
        dev_ok    = (32'(item.device) < dbbt_pkg::NUM_DEVICES);
        life_cur  = life_reg[item.device];
        tick_cur  = tick_reg[item.device];
        stall_cur = stall_reg[item.device];
        life_sum  = life_cur + dbbt_pkg::LIFE_W'(item.byte_count);
        tick_sum  = {1'b0, tick_cur} + (dbbt_pkg::TICK_W + 1)'(item.byte_count);
        tick_sat  = tick_sum[dbbt_pkg::TICK_W] ? '1 : tick_sum[dbbt_pkg::TICK_W-1:0];
        stall_inc = (stall_cur == '1) ? stall_cur : stall_cur + 32'd1;
        cls       = cfg.dev_class[item.device];
        unique case (cls)
            dbbt_pkg::CLASS_HIGH:   budget = cfg.budget_high;
            dbbt_pkg::CLASS_NORMAL: budget = cfg.budget_normal;
            default:                budget = cfg.budget_low;
        endcase
        defer_hit = (cls != dbbt_pkg::CLASS_RT) &&
                    (tick_cur > dbbt_pkg::TICK_W'(budget));
    end

    // Next counter values.
    always_comb begin
        life_next  = life_reg;
        tick_next  = tick_reg;
        stall_next = stall_reg;
        if (item_valid) begin
            priority if (item.op == dbbt_pkg::OP_TICK) begin
                for (int i = 0; i < dbbt_pkg::NUM_DEVICES; i++) begin
                    tick_next[i] = '0;
                end
            end else if (dev_ok) begin
                unique case (item.op)
                    dbbt_pkg::OP_REPORT: begin
                        life_next[item.device] = life_sum;
                        tick_next[item.device] = tick_sat;
                    end
                    dbbt_pkg::OP_QUERY: begin
                        if (defer_hit) begin
                            stall_next[item.device] = stall_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result fields, read after the update.
    always_comb begin
        res = '0;
        if (item.op != dbbt_pkg::OP_TICK && dev_ok) begin
            res.defer       = (item.op == dbbt_pkg::OP_QUERY) && defer_hit;
            res.total_bytes = (item.op == dbbt_pkg::OP_REPORT) ? life_sum : life_cur;
            res.stall_count = res.defer ? stall_inc : stall_cur;
        end
    end

    // Counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dbbt_pkg::NUM_DEVICES; i++) begin
                life_reg[i]  <= '0;
                tick_reg[i]  <= '0;
                stall_reg[i] <= '0;
            end
        end else begin
            life_reg  <= life_next;
            tick_reg  <= tick_next;
            stall_reg <= stall_next;
        end
    end

`ifndef SYNTHESIS
    // A realtime device is never deferred.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.defer |-> (cls != dbbt_pkg::CLASS_RT))
        else $error("defer raised for a realtime device");

    // A committed deferral advances the stall counter unless it is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && res.defer && (stall_cur != '1))
        |=> (stall_reg[$past(item.device)] == $past(stall_cur) + 32'd1))
        else $error("stall counter did not advance on a deferral");

    // A tick clears the per-tick counts of all devices; this checks the device it names.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && (item.op == dbbt_pkg::OP_TICK))
        |=> (tick_reg[$past(item.device)] == '0))
        else $error("per-tick count survived a tick");
`endif

endmodule

`default_nettype wire

[rtl/dma_bandwidth_budget_throttle_unit.sv]
// Top level of the DMA bandwidth budget throttle: stream ports, input and
// result registers. Depends on dbbt_pkg, dbbt_cfg_regs and dbbt_counter_bank.
`default_nettype none

// The block keeps lifetime, per-tick and stall counters for four DMA devices
// and answers one result beat for every input beat. Each beat waits in the
// input register, where the counter read-modify-write happens as it moves on,
// and then sits in the result register until taken, so a new beat is taken
// every cycle while the result stream does not stall. Result valid rises once
// the beat has passed from the input register into the result register.
// A stalled result register holds the input register and then the input
// port. Configuration writes take effect on the next edge and should be made
// only while no beat is in flight.
module dma_bandwidth_budget_throttle_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [dbbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dbbt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: device [1:0], byte_count [33:2], zero [39:34].
    input  wire logic [dbbt_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: operation [1:0].
    input  wire logic [dbbt_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: defer [0], total_bytes [48:1], stall_count [80:49], zero [87:81].
    output logic [dbbt_pkg::M_TDATA_W-1:0]         m_tdata
);

    dbbt_pkg::cfg_t    cfg;
    dbbt_pkg::item_t   in_item_reg;
    dbbt_pkg::result_t res;
    dbbt_pkg::result_t out_res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              fire;

    dbbt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dbbt_counter_bank u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (fire),
        .item       (in_item_reg),
        .res        (res)
    );

    // Handshake: the result register moves when empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op         <= dbbt_pkg::op_t'(s_tuser[1:0]);
            in_item_reg.device     <= s_tdata[1:0];
            in_item_reg.byte_count <= s_tdata[33:2];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    // Pack the result beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.stall_count, out_res_reg.total_bytes,
                       out_res_reg.defer};

`ifndef SYNTHESIS
    // A result appears only from a beat held in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result valid rose without an input beat");

    // A beat in the input register waits while the result is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready)
        |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input beat lost while the result stalled");

    // A stalled result beat stays valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");
`endif

endmodule

`default_nettype wire
